// ----- hdl/dvru_pkg.sv -----
// Shared types and constants of the distance-vector route update core.
package dvru_pkg;

   localparam int COST_W = 16;
   localparam int NODE_W = 3;
   localparam int HOP_W = 4;

   localparam int DEF_NODES = 8;
   localparam int DEF_INFINITE_COST = 65535;

   localparam logic KIND_LINK = 1'b0;
   localparam logic KIND_VECTOR = 1'b1;
   localparam logic OUT_ROUTE = 1'b0;
   localparam logic OUT_ADVERT = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [NODE_W-1:0] peer;
      logic [COST_W-1:0] in_cost;
      logic [NODE_W-1:0] in_target;
      logic              in_last;
   } req_type;

   typedef struct packed {
      logic              out_kind;
      logic [NODE_W-1:0] dest_node;
      logic [NODE_W-1:0] out_target;
      logic [COST_W-1:0] out_cost;
      logic [HOP_W-1:0]  next_hop;
      logic              out_last;
   } rsp_type;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_COMMIT   = 9'b000000010,
      S_SCAN_RD  = 9'b000000100,
      S_SCAN_ACC = 9'b000001000,
      S_OWN_RD   = 9'b000010000,
      S_OWN_CMP  = 9'b000100000,
      S_ADV_RD   = 9'b001000000,
      S_ADV_EMIT = 9'b010000000,
      S_FINISH   = 9'b100000000
   } state_type;

endpackage

// ----- hdl/dvru_cost_store.sv -----
// Cost matrix memory with per-entry valid bits that stand in for the reset contents.
module dvru_cost_store #(
   parameter int NODES = dvru_pkg::DEF_NODES,
   parameter int INFINITE_COST = dvru_pkg::DEF_INFINITE_COST,
   localparam int IDX_W = $clog2(NODES),
   localparam int ADDR_W = 2 * IDX_W,
   localparam int DEPTH = 2 ** ADDR_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_row,
   input  logic [IDX_W-1:0]            wr_col,
   input  logic [dvru_pkg::COST_W-1:0] wr_cost,
   input  logic [IDX_W-1:0]            rd_row,
   input  logic [IDX_W-1:0]            rd_col,
   output logic [dvru_pkg::COST_W-1:0] rd_cost
);

   logic [dvru_pkg::COST_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]            vld_ff;
   logic [DEPTH-1:0]            vld_in;
   logic [dvru_pkg::COST_W-1:0] rd_data_ff;
   logic                        rd_vld_ff;
   logic                        rd_diag_ff;
   logic [ADDR_W-1:0]           wr_addr;
   logic [ADDR_W-1:0]           rd_addr;

   assign wr_addr = {wr_row, wr_col};
   assign rd_addr = {rd_row, rd_col};

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_cost;
      end
      rd_data_ff <= mem[rd_addr];
      rd_diag_ff <= (rd_row == rd_col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   // An entry never written reads as its reset value: zero on the diagonal, else infinity.
   assign rd_cost = rd_vld_ff ? rd_data_ff :
                    (rd_diag_ff ? '0 : dvru_pkg::COST_W'(INFINITE_COST));

endmodule

// ----- hdl/distance_vector_route_update_core.sv -----
// A vector element that is not last is stored while idle and starts no run; a
// link update, or a last vector element from a peer other than this node, starts
// a run: commit (vector runs only), route scan, then advertisements if a route changed.
// No request is taken while a run is in progress; the single add-and-compare unit and
// the one read port of the cost matrix set the pace. Reset is synchronous, active high;
// it restores the cost matrix through valid bits and the link and next-hop tables.
module distance_vector_route_update_core #(
   parameter int NODES = dvru_pkg::DEF_NODES,
   parameter int INFINITE_COST = dvru_pkg::DEF_INFINITE_COST
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dvru_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dvru_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [dvru_pkg::NODE_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(NODES);
   localparam int CW = dvru_pkg::COST_W;
   localparam int HW = dvru_pkg::HOP_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);
   localparam logic [CW-1:0] INF = CW'(INFINITE_COST);

   // Sequencer state and the working registers of one run.
   dvru_pkg::state_type state_ff, state_in;
   logic [dvru_pkg::NODE_W-1:0] own_ff;
   logic [IDX_W-1:0] peer_ff, peer_in;
   logic [IDX_W-1:0] t_ff, t_in;
   logic [IDX_W-1:0] a_ff, a_in;
   logic [CW-1:0]    best_ff, best_in;
   logic [HW-1:0]    hop_ff, hop_in;
   logic             changed_ff, changed_in;

   // The last result produced is held back one step so that out_last can be
   // set on it when the run ends.
   dvru_pkg::rsp_type hold_ff, hold_in;
   logic              hold_vld_ff, hold_vld_in;
   dvru_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Small tables held in flops.
   logic [CW-1:0] link_ff [NODES];
   logic [CW-1:0] pend_ff [NODES];
   logic [HW-1:0] nh_ff   [NODES];

   logic             accept;
   logic             req_ok;
   logic [CW-1:0]    cost_clamp;
   logic [IDX_W-1:0] own_idx;
   logic [CW-1:0]    link_a;
   logic             a_usable;
   logic [CW:0]      sum;
   logic [CW-1:0]    cand;
   logic             can_push;
   logic             gen_go;
   logic [CW-1:0]    rd_cost;
   logic             differ;
   logic [HW-1:0]    nh_t;
   logic             link_we, pend_we, nh_we;
   logic             wr_en;
   logic [IDX_W-1:0] wr_row, wr_col, rd_row;
   logic [CW-1:0]    wr_cost;
   dvru_pkg::rsp_type gen;
   logic             gen_req;

   dvru_cost_store #(
      .NODES        (NODES),
      .INFINITE_COST(INFINITE_COST)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (wr_en),
      .wr_row (wr_row),
      .wr_col (wr_col),
      .wr_cost(wr_cost),
      .rd_row (rd_row),
      .rd_col (t_ff),
      .rd_cost(rd_cost)
   );

   assign req_stall = (state_ff != dvru_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign req_ok    = (int'(req_data.peer) < NODES) && (int'(own_ff) < NODES);
   assign cost_clamp = (req_data.in_cost > INF) ? INF : req_data.in_cost;
   assign own_idx   = IDX_W'(own_ff);

   // The shared unit: one saturating add and one compare.
   assign link_a   = link_ff[a_ff];
   assign a_usable = (a_ff != own_idx) && (link_a < INF);
   assign sum      = {1'b0, link_a} + {1'b0, rd_cost};
   assign cand     = (sum >= {1'b0, INF}) ? INF : sum[CW-1:0];
   assign differ   = (rd_cost != best_ff);
   assign nh_t     = nh_ff[t_ff];

   assign can_push = !rsp_valid_ff || !rsp_stall;
   assign gen_go   = !hold_vld_ff || can_push;

   // The route scan reads neighbor rows; every other read is of this node's row.
   assign rd_row = (state_ff == dvru_pkg::S_SCAN_RD) ? a_ff : own_idx;

   always_comb begin
      state_in     = state_ff;
      peer_in      = peer_ff;
      t_in         = t_ff;
      a_in         = a_ff;
      best_in      = best_ff;
      hop_in       = hop_ff;
      changed_in   = changed_ff;
      link_we      = 1'b0;
      pend_we      = 1'b0;
      nh_we        = 1'b0;
      wr_en        = 1'b0;
      wr_row       = peer_ff;
      wr_col       = a_ff;
      wr_cost      = pend_ff[a_ff];
      gen_req      = 1'b0;
      gen          = '0;

      case (state_ff)
         dvru_pkg::S_IDLE: begin
            t_in       = '0;
            a_in       = '0;
            best_in    = INF;
            hop_in     = HW'(own_ff);
            changed_in = 1'b0;
            if (accept && req_ok) begin
               peer_in = IDX_W'(req_data.peer);
               if (req_data.kind == dvru_pkg::KIND_LINK) begin
                  link_we  = 1'b1;
                  state_in = dvru_pkg::S_SCAN_RD;
               end else begin
                  pend_we = (int'(req_data.in_target) < NODES);
                  if (req_data.in_last && (req_data.peer != own_ff)) begin
                     state_in = dvru_pkg::S_COMMIT;
                  end
               end
            end
         end

         dvru_pkg::S_COMMIT: begin
            wr_en = 1'b1;
            if (a_ff == LAST_IDX) begin
               a_in     = '0;
               state_in = dvru_pkg::S_SCAN_RD;
            end else begin
               a_in = a_ff + 1'b1;
            end
         end

         dvru_pkg::S_SCAN_RD: begin
            if (t_ff == own_idx) begin
               // This node's own entry is never recomputed.
               if (t_ff == LAST_IDX) begin
                  state_in = changed_ff ? dvru_pkg::S_ADV_RD : dvru_pkg::S_FINISH;
                  t_in     = '0;
               end else begin
                  t_in = t_ff + 1'b1;
               end
            end else begin
               state_in = dvru_pkg::S_SCAN_ACC;
            end
         end

         dvru_pkg::S_SCAN_ACC: begin
            if (a_usable && (cand < best_ff)) begin
               best_in = cand;
               hop_in  = HW'(a_ff);
            end
            if (a_ff == LAST_IDX) begin
               a_in     = '0;
               state_in = dvru_pkg::S_OWN_RD;
            end else begin
               a_in     = a_ff + 1'b1;
               state_in = dvru_pkg::S_SCAN_RD;
            end
         end

         dvru_pkg::S_OWN_RD: begin
            state_in = dvru_pkg::S_OWN_CMP;
         end

         dvru_pkg::S_OWN_CMP: begin
            gen.out_kind   = dvru_pkg::OUT_ROUTE;
            gen.out_target = dvru_pkg::NODE_W'(t_ff);
            gen.out_cost   = best_ff;
            gen.next_hop   = hop_ff;
            if (!differ || gen_go) begin
               if (differ) begin
                  gen_req    = 1'b1;
                  wr_en      = 1'b1;
                  wr_row     = own_idx;
                  wr_col     = t_ff;
                  wr_cost    = best_ff;
                  nh_we      = 1'b1;
                  changed_in = 1'b1;
               end
               best_in = INF;
               hop_in  = HW'(own_ff);
               if (t_ff == LAST_IDX) begin
                  t_in     = '0;
                  state_in = (changed_ff || differ) ? dvru_pkg::S_ADV_RD
                                                    : dvru_pkg::S_FINISH;
               end else begin
                  t_in     = t_ff + 1'b1;
                  state_in = dvru_pkg::S_SCAN_RD;
               end
            end
         end

         dvru_pkg::S_ADV_RD: begin
            if (a_usable) begin
               state_in = dvru_pkg::S_ADV_EMIT;
            end else if (a_ff == LAST_IDX) begin
               state_in = dvru_pkg::S_FINISH;
            end else begin
               a_in = a_ff + 1'b1;
            end
         end

         dvru_pkg::S_ADV_EMIT: begin
            // Poison reverse: a route through this neighbor is sent back as infinity.
            gen.out_kind   = dvru_pkg::OUT_ADVERT;
            gen.dest_node  = dvru_pkg::NODE_W'(a_ff);
            gen.out_target = dvru_pkg::NODE_W'(t_ff);
            gen.out_cost   = (nh_t == HW'(a_ff)) ? INF : rd_cost;
            gen.next_hop   = nh_t;
            if (gen_go) begin
               gen_req = 1'b1;
               if (t_ff == LAST_IDX) begin
                  t_in = '0;
                  if (a_ff == LAST_IDX) begin
                     state_in = dvru_pkg::S_FINISH;
                  end else begin
                     a_in     = a_ff + 1'b1;
                     state_in = dvru_pkg::S_ADV_RD;
                  end
               end else begin
                  t_in     = t_ff + 1'b1;
                  state_in = dvru_pkg::S_ADV_RD;
               end
            end
         end

         dvru_pkg::S_FINISH: begin
            if (!hold_vld_ff || can_push) begin
               state_in = dvru_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = dvru_pkg::S_IDLE;
         end
      endcase
   end

   // Output register and the held-back result.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      hold_in      = hold_ff;
      hold_vld_in  = hold_vld_ff;
      if (gen_req) begin
         if (hold_vld_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = hold_ff;
         end
         hold_in     = gen;
         hold_vld_in = 1'b1;
      end else if ((state_ff == dvru_pkg::S_FINISH) && hold_vld_ff && can_push) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in          = hold_ff;
         rsp_data_in.out_last = 1'b1;
         hold_vld_in          = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dvru_pkg::S_IDLE;
         own_ff       <= '0;
         changed_ff   <= 1'b0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NODES; i++) begin
            link_ff[i] <= INF;
            nh_ff[i]   <= HW'(NODES);
         end
      end else begin
         state_ff     <= state_in;
         changed_ff   <= changed_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            own_ff <= csr_wdata;
         end
         if (link_we) begin
            link_ff[IDX_W'(req_data.peer)] <= cost_clamp;
         end
         if (nh_we) begin
            nh_ff[t_ff] <= hop_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      peer_ff     <= peer_in;
      t_ff        <= t_in;
      a_ff        <= a_in;
      best_ff     <= best_in;
      hop_ff      <= hop_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
      if (pend_we) begin
         pend_ff[IDX_W'(req_data.in_target)] <= cost_clamp;
      end
   end

endmodule
